/* sv/pulse_period_tachometer_macros.svh */
// Assertion macros shared by the tachometer checker.
`ifndef PULSE_PERIOD_TACHOMETER_MACROS_SVH
`define PULSE_PERIOD_TACHOMETER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tachometer check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define PPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tachometer check failed");

`endif

/* sv/ppt_pkg.sv */
// Types and constants shared by the pulse period tachometer modules.
package ppt_pkg;

    localparam int TIME_W    = 48;
    localparam int PERIOD_W  = 32;
    localparam int RPM_W     = 26;
    localparam int CFG_IDX_W = 2;

    localparam logic [RPM_W-1:0] RPM_NUM = 26'd60000000;
    localparam logic [PERIOD_W-1:0] TIMEOUT_RESET = 32'd2000000;

    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_FLOOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd1;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] OUT_GLITCH  = 2'd0;
    localparam logic [1:0] OUT_STORED  = 2'd1;
    localparam logic [1:0] OUT_RESTART = 2'd2;
    localparam logic [1:0] OUT_FIRST   = 2'd3;

    localparam logic [1:0] STAT_NO_SIGNAL = 2'd0;
    localparam logic [1:0] STAT_OK        = 2'd1;
    localparam logic [1:0] STAT_UNSTABLE  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_EV_CHK,
        S_EV_READ,
        S_EV_MED,
        S_EV_HI,
        S_EV_SPREAD,
        S_EV_JUDGE,
        S_EV_DIV,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic                start;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

endpackage

/* sv/pulse_period_tachometer.sv */
// Top level of the median-filtered pulse period tachometer.
//
// An item is transferred in when i_start is high and o_busy is low; i_opcode
// selects a sensor edge or an evaluate request and i_time_us carries its
// microsecond timestamp. Each item produces exactly one result, shown for one
// cycle with o_done high; the receiver cannot hold it off, so the block never
// waits on the output side. o_busy stays high from the transfer until the
// result appears, and the next item may be transferred in the cycle o_done is high.
// An edge item passes through S_EDGE and then S_REPORT. An evaluate request that
// finds no signal goes from S_EV_CHK straight to S_REPORT; otherwise it reads
// the newest held periods, up to the window size, from the ring memory, one
// period per cycle, sorting them into the window, then finds the median, the
// spread and the stability verdict and, unless the median is zero, runs the bit-serial rpm division.
// Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data at any edge and should change only while the block is idle.
// Synchronous reset clears all counters, the timebase and the held periods;
// the ring contents themselves are not cleared and are read only after writing.
module pulse_period_tachometer
    import ppt_pkg::*;
#(
    parameter int RING_DEPTH    = 16,
    parameter int MEDIAN_WINDOW = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_opcode,
    input  logic [TIME_W-1:0]    i_time_us,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PERIOD_W-1:0]  i_cfg_data,
    output logic                 o_done,
    output logic [1:0]           o_edge_outcome,
    output logic [1:0]           o_signal_status,
    output logic [PERIOD_W-1:0]  o_median_period_us,
    output logic [RPM_W-1:0]     o_speed_rpm,
    output logic [31:0]          o_pulses_seen,
    output logic [31:0]          o_glitches_seen,
    output logic [31:0]          o_missed_seen,
    output logic [4:0]           o_periods_held
);

    localparam int HW = $clog2(RING_DEPTH);
    localparam int VW = $clog2(RING_DEPTH + 1);
    localparam int NW = $clog2(MEDIAN_WINDOW + 1);
    localparam int SW = $clog2(MEDIAN_WINDOW);
    localparam int CW = (VW > NW) ? VW : NW;

    t_state r_state, n_state;

    logic [PERIOD_W-1:0] r_glitch_floor;
    logic [PERIOD_W-1:0] r_timeout;

    logic [HW-1:0]       r_head;
    logic [VW-1:0]       r_valid;
    logic [TIME_W-1:0]   r_last_time;
    logic                r_have_last;
    logic [31:0]         r_pulse_total;
    logic [31:0]         r_glitch_total;
    logic [31:0]         r_missed_total;
    logic [PERIOD_W-1:0] r_afloor;
    logic [31:0]         r_checked_total;

    logic [TIME_W-1:0]   r_time;
    logic [TIME_W-1:0]   r_gap;

    logic [NW-1:0]       r_n;
    logic [NW-1:0]       r_issue;
    logic [NW-1:0]       r_recv;
    logic                r_rvalid;
    logic [HW-1:0]       r_rd_addr;
    logic [PERIOD_W-1:0] r_win [MEDIAN_WINDOW];
    logic [PERIOD_W-1:0] n_win [MEDIAN_WINDOW];
    logic [PERIOD_W-1:0] r_newest;
    logic [PERIOD_W-1:0] r_med;
    logic [PERIOD_W-1:0] r_hi;
    logic [PERIOD_W-1:0] r_lo;
    logic [PERIOD_W-1:0] r_spread;

    logic [1:0]          r_res_outcome;
    logic [1:0]          r_res_status;
    logic [PERIOD_W-1:0] r_res_med;
    logic [RPM_W-1:0]    r_res_rpm;

    logic                r_done;

    logic                mem_we;
    logic [HW-1:0]       mem_waddr;
    logic [PERIOD_W-1:0] mem_wdata;
    logic [PERIOD_W-1:0] mem_rdata;

    t_div_req            div_req;
    logic                div_done;
    logic [RPM_W-1:0]    div_quo;

    logic [PERIOD_W-1:0] edge_floor;
    logic                is_glitch;
    logic                in_time;
    logic [PERIOD_W-1:0] clamped_gap;
    logic [HW-1:0]       head_inc;
    logic [HW-1:0]       newest_addr;
    logic [HW-1:0]       rd_addr_dec;
    logic                no_signal;
    logic                wide_win;
    logic [SW-1:0]       w_sel;
    logic [PERIOD_W-1:0] w_pick;
    logic                lt [MEDIAN_WINDOW];
    logic                missed_hit;
    logic                unstable;

    ppt_ring #(
        .DEPTH(RING_DEPTH),
        .AW   (HW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(r_rd_addr),
        .o_rdata(mem_rdata)
    );

    ppt_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    always_comb begin
        edge_floor  = (r_afloor > r_glitch_floor) ? r_afloor : r_glitch_floor;
        is_glitch   = (r_gap < {16'b0, edge_floor});
        in_time     = (r_gap <= {16'b0, r_timeout});
        clamped_gap = (|r_gap[TIME_W-1:PERIOD_W]) ? '1 : r_gap[PERIOD_W-1:0];
        head_inc    = (r_head == HW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
        newest_addr = (r_head == '0) ? HW'(RING_DEPTH - 1) : r_head - 1'b1;
        rd_addr_dec = (r_rd_addr == '0) ? HW'(RING_DEPTH - 1) : r_rd_addr - 1'b1;
        no_signal   = (r_valid < VW'(2)) || !r_have_last || (r_gap > {16'b0, r_timeout});
        wide_win    = (32'(r_n) >= 32'd4);
        missed_hit  = (r_pulse_total != r_checked_total)
                   && ({1'b0, r_newest} > ({1'b0, r_med} + {2'b0, r_med[PERIOD_W-1:1]}))
                   && ({2'b0, r_newest} < ({2'b0, r_med} + {1'b0, r_med, 1'b0}));
        unstable    = wide_win
                   && (({3'b0, r_spread} + {1'b0, r_spread, 2'b0}) > {3'b0, r_med});
    end

    always_comb begin
        if (r_state == S_EV_MED) begin
            w_sel = SW'(r_n >> 1);
        end else if (wide_win) begin
            w_sel = SW'(r_n - NW'(2));
        end else begin
            w_sel = SW'(r_n - NW'(1));
        end
        w_pick = r_win[w_sel];
    end

    always_comb begin
        for (int k = 0; k < MEDIAN_WINDOW; k++) begin
            lt[k] = (NW'(k) < r_recv) && (r_win[k] <= mem_rdata);
        end
        n_win[0] = lt[0] ? r_win[0] : mem_rdata;
        for (int k = 1; k < MEDIAN_WINDOW; k++) begin
            n_win[k] = lt[k] ? r_win[k] : (lt[k-1] ? mem_rdata : r_win[k-1]);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_opcode == OP_EVAL) ? S_EV_CHK : S_EDGE;
                end
            end
            S_EDGE:      n_state = S_REPORT;
            S_EV_CHK:    n_state = no_signal ? S_REPORT : S_EV_READ;
            S_EV_READ:   n_state = (r_recv == r_n) ? S_EV_MED : S_EV_READ;
            S_EV_MED:    n_state = S_EV_HI;
            S_EV_HI:     n_state = S_EV_SPREAD;
            S_EV_SPREAD: n_state = S_EV_JUDGE;
            S_EV_JUDGE:  n_state = (r_med == '0) ? S_REPORT : S_EV_DIV;
            S_EV_DIV:    n_state = div_done ? S_REPORT : S_EV_DIV;
            S_REPORT:    n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we          = 1'b0;
        mem_waddr       = r_head;
        mem_wdata       = clamped_gap;
        div_req.start   = 1'b0;
        div_req.divisor = r_med;
        unique case (r_state)
            S_EDGE:     mem_we = r_have_last && !is_glitch && in_time;
            S_EV_JUDGE: div_req.start = (r_med != '0);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glitch_floor <= '0;
            r_timeout      <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GLITCH_FLOOR: r_glitch_floor <= i_cfg_data;
                CFG_TIMEOUT:      r_timeout      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head          <= '0;
            r_valid         <= '0;
            r_last_time     <= '0;
            r_have_last     <= 1'b0;
            r_pulse_total   <= '0;
            r_glitch_total  <= '0;
            r_missed_total  <= '0;
            r_afloor        <= '0;
            r_checked_total <= '0;
            r_issue         <= '0;
            r_recv          <= '0;
            r_rvalid        <= 1'b0;
            r_done          <= 1'b0;
        end else begin
            r_done   <= (r_state == S_REPORT);
            r_rvalid <= 1'b0;
            unique case (r_state)
                S_EDGE: begin
                    if (r_have_last && is_glitch) begin
                        r_glitch_total <= r_glitch_total + 1'b1;
                    end else begin
                        if (r_have_last && in_time) begin
                            r_head <= head_inc;
                            if (r_valid != VW'(RING_DEPTH)) begin
                                r_valid <= r_valid + 1'b1;
                            end
                        end else if (r_have_last) begin
                            r_valid <= '0;
                        end
                        r_last_time   <= r_time;
                        r_have_last   <= 1'b1;
                        r_pulse_total <= r_pulse_total + 1'b1;
                    end
                end
                S_EV_CHK: begin
                    r_issue <= '0;
                    r_recv  <= '0;
                    if (no_signal) begin
                        r_afloor        <= '0;
                        r_checked_total <= r_pulse_total;
                    end
                end
                S_EV_READ: begin
                    if (r_issue != r_n) begin
                        r_issue  <= r_issue + 1'b1;
                        r_rvalid <= 1'b1;
                    end
                    if (r_rvalid) begin
                        r_recv <= r_recv + 1'b1;
                    end
                end
                S_EV_SPREAD: begin
                    if (missed_hit) begin
                        r_missed_total <= r_missed_total + 1'b1;
                    end
                    r_checked_total <= r_pulse_total;
                    r_afloor        <= wide_win ? {2'b0, r_hi[PERIOD_W-1:2]} : '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_time        <= i_time_us;
                r_gap         <= i_time_us - r_last_time;
                r_res_outcome <= OUT_GLITCH;
                r_res_status  <= STAT_NO_SIGNAL;
                r_res_med     <= '0;
                r_res_rpm     <= '0;
            end
            S_EDGE: begin
                if (!r_have_last) begin
                    r_res_outcome <= OUT_FIRST;
                end else if (is_glitch) begin
                    r_res_outcome <= OUT_GLITCH;
                end else if (in_time) begin
                    r_res_outcome <= OUT_STORED;
                end else begin
                    r_res_outcome <= OUT_RESTART;
                end
            end
            S_EV_CHK: begin
                r_rd_addr <= newest_addr;
                if (CW'(r_valid) < CW'(MEDIAN_WINDOW)) begin
                    r_n <= NW'(r_valid);
                end else begin
                    r_n <= NW'(MEDIAN_WINDOW);
                end
            end
            S_EV_READ: begin
                if (r_issue != r_n) begin
                    r_rd_addr <= rd_addr_dec;
                end
                if (r_rvalid) begin
                    for (int k = 0; k < MEDIAN_WINDOW; k++) begin
                        r_win[k] <= n_win[k];
                    end
                    if (r_recv == '0) begin
                        r_newest <= mem_rdata;
                    end
                end
            end
            S_EV_MED: begin
                r_med <= w_pick;
            end
            S_EV_HI: begin
                r_hi <= w_pick;
                r_lo <= wide_win ? r_win[1] : r_win[0];
            end
            S_EV_SPREAD: begin
                r_spread <= r_hi - r_lo;
            end
            S_EV_JUDGE: begin
                r_res_status <= unstable ? STAT_UNSTABLE : STAT_OK;
                r_res_med    <= r_med;
                r_res_rpm    <= RPM_NUM;
            end
            S_EV_DIV: begin
                if (div_done) begin
                    r_res_rpm <= div_quo;
                end
            end
            S_REPORT: begin
                o_edge_outcome     <= r_res_outcome;
                o_signal_status    <= r_res_status;
                o_median_period_us <= r_res_med;
                o_speed_rpm        <= r_res_rpm;
                o_pulses_seen      <= r_pulse_total;
                o_glitches_seen    <= r_glitch_total;
                o_missed_seen      <= r_missed_total;
                o_periods_held     <= 5'(r_valid);
            end
            default: begin
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

/* sv/ppt_ring.sv */
// Period ring memory with one write port and one registered read port.
module ppt_ring
    import ppt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic [PERIOD_W-1:0] i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output logic [PERIOD_W-1:0] o_rdata
);

    logic [PERIOD_W-1:0] r_mem [DEPTH];
    logic [PERIOD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ppt_div.sv */
// Restoring divider that forms the rpm constant divided by a period, one bit per cycle.
module ppt_div
    import ppt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [RPM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(RPM_W);

    logic                r_run;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_div;
    logic [RPM_W-1:0]    r_quo;
    logic [PERIOD_W:0]   trial;
    logic                ge;

    always_comb begin
        trial = {r_rem, r_quo[RPM_W-1]};
        ge    = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RPM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_quo <= RPM_NUM;
        end else if (r_run) begin
            r_rem <= ge ? PERIOD_W'(trial - {1'b0, r_div}) : trial[PERIOD_W-1:0];
            r_quo <= {r_quo[RPM_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* sv/ppt_checker.sv */
// Port-level checks for the pulse period tachometer and their binding.
`include "pulse_period_tachometer_macros.svh"

module ppt_checker
    import ppt_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input logic                 o_busy,
    input logic                 o_done,
    input logic [1:0]           o_edge_outcome,
    input logic [1:0]           o_signal_status,
    input logic [PERIOD_W-1:0]  o_median_period_us,
    input logic [RPM_W-1:0]     o_speed_rpm
);

    `PPT_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, o_done, !o_done)
    `PPT_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `PPT_ASSERT_NOW(a_idle_on_result, i_clk, i_rst_n, o_done, !o_busy)
    `PPT_ASSERT_NOW(a_one_kind, i_clk, i_rst_n, o_done, (o_edge_outcome == OUT_GLITCH) || (o_signal_status == STAT_NO_SIGNAL))
    `PPT_ASSERT_NOW(a_no_signal_zero, i_clk, i_rst_n, o_done && (o_signal_status == STAT_NO_SIGNAL), (o_median_period_us == '0) && (o_speed_rpm == '0))

endmodule

bind pulse_period_tachometer ppt_checker u_ppt_checker (.*);
